@@ hdl/tarl_pkg.sv @@
`default_nettype none

package tarl_pkg;

   // Axis count and fixed-point widths
   localparam int unsigned AxisCount = 3;
   localparam int unsigned SampleW   = 16;
   localparam int unsigned CfgW      = 15;
   localparam int unsigned MaskW     = 3;
   // Working width: holds v +/- a doubled 15-bit step with no wrap
   localparam int unsigned CalcW     = 19;
   localparam logic signed [CalcW-1:0] VelLimit = 19'sd16384;

   // Configuration register indexes
   typedef enum logic [2:0] {
      REG_DEADZONE_X  = 3'd0,
      REG_DEADZONE_Y  = 3'd1,
      REG_DEADZONE_R  = 3'd2,
      REG_ACCEL_X     = 3'd3,
      REG_ACCEL_Y     = 3'd4,
      REG_ACCEL_R     = 3'd5,
      REG_INVERT_MASK = 3'd6,
      REG_SPEED_FLOOR = 3'd7
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [CfgW-1:0]  DeadzoneReset    = 15'd0;
   localparam logic [CfgW-1:0]  AccelReset       = 15'd4096;
   localparam logic [MaskW-1:0] InvertMaskReset  = 3'd0;
   localparam logic [CfgW-1:0]  VelDeadzoneReset = 15'd0;

   // One ramp step of one axis: stick deadzone, invert, step, velocity
   // deadzone, saturation
   function automatic logic signed [SampleW-1:0] ramp_axis(
      input logic signed [SampleW-1:0] vel,
      input logic signed [SampleW-1:0] sample,
      input logic [CfgW-1:0]           deadzone,
      input logic [CfgW-1:0]           accel,
      input logic                      invert,
      input logic [CfgW-1:0]           speed_floor
   );
      logic signed [CalcW-1:0] t;
      logic signed [CalcW-1:0] t_mag;
      logic signed [CalcW-1:0] v;
      logic signed [CalcW-1:0] v_mag;
      logic signed [CalcW-1:0] step;
      logic signed [CalcW-1:0] sum;
      logic signed [CalcW-1:0] nv;
      logic signed [CalcW-1:0] dz_s;
      logic signed [CalcW-1:0] vdz_s;
      t     = CalcW'(sample);
      v     = CalcW'(vel);
      dz_s  = $signed({{(CalcW-CfgW){1'b0}}, deadzone});
      vdz_s = $signed({{(CalcW-CfgW){1'b0}}, speed_floor});
      // Drop small stick deflections, then flip if asked
      t_mag = (t < 0) ? -t : t;
      if (t_mag < dz_s) begin
         t = '0;
      end
      if (invert) begin
         t = -t;
      end
      // Double the step when returning to center
      if (t == 0) begin
         step = $signed({{(CalcW-CfgW-1){1'b0}}, accel, 1'b0});
      end else begin
         step = $signed({{(CalcW-CfgW){1'b0}}, accel});
      end
      // Move toward the target; hold rather than overshoot on the way up
      sum = v + step;
      nv  = v;
      if (v < t) begin
         if (sum <= t) begin
            nv = sum;
         end
      end else if (v > t) begin
         nv = v - step;
      end
      // Zero small velocities, then clamp
      v_mag = (nv < 0) ? -nv : nv;
      if (v_mag < vdz_s) begin
         nv = '0;
      end
      if (nv > VelLimit) begin
         nv = VelLimit;
      end
      if (nv < -VelLimit) begin
         nv = -VelLimit;
      end
      return nv[SampleW-1:0];
   endfunction

endpackage

`default_nettype wire

@@ hdl/three_axis_ramp_limiter_unit.sv @@
`default_nettype none

// Three-axis ramp limiter with stick and velocity deadzones.
// Request channel (req_valid / req_stall): one word per control update,
// carrying three signed Q1.14 stick samples, or a clear word (req_type = 1)
// that zeroes all three velocities. Response channel (rsp_valid /
// rsp_stall): exactly one word per request, carrying the three velocities
// as they stand after that request.
// Config port (csr_*): write-only registers for deadzones, ramp steps,
// invert mask and velocity deadzone; write them only while no word is in
// flight.
// A request is captured in the input register and then moves into the
// output register (one input register, one output register). Throughput: one word
// per cycle while rsp_stall is low; the per-axis compare/add logic between the two
// registers is combinational.
// Stall: when rsp_stall holds a full output register, the input register
// keeps its word and req_stall rises in the same cycle; nothing is dropped.
// Reset (synchronous, active high): velocities cleared to zero, registers
// back to their defaults, both pipeline stages emptied.
module three_axis_ramp_limiter_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_type,
   input  wire logic signed [15:0]            req_stick_x,
   input  wire logic signed [15:0]            req_stick_y,
   input  wire logic signed [15:0]            req_stick_r,
   // response channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [15:0]            rsp_vel_x,
   output      logic signed [15:0]            rsp_vel_y,
   output      logic signed [15:0]            rsp_vel_r,
   // configuration port
   input  wire logic                          csr_write_en,
   input  wire tarl_pkg::csr_index_type       csr_index,
   input  wire logic [14:0]                   csr_wdata
);
   import tarl_pkg::*;

   // configuration registers
   logic [CfgW-1:0]  deadzone_ff [AxisCount];
   logic [CfgW-1:0]  accel_ff [AxisCount];
   logic [MaskW-1:0] invert_mask_ff;
   logic [CfgW-1:0]  speed_floor_ff;

   // input stage
   logic                     in_valid_ff;
   logic                     in_clear_ff;
   logic signed [SampleW-1:0] in_stick_ff [AxisCount];

   // velocity state and output stage
   logic signed [SampleW-1:0] vel_ff [AxisCount];
   logic signed [SampleW-1:0] vel_in [AxisCount];
   logic                      rsp_valid_ff;
   logic signed [SampleW-1:0] rsp_vel_ff [AxisCount];

   logic out_free;
   logic advance;
   logic req_take;

   // Move a word forward when the output register is empty or being taken
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AxisCount; i++) begin
            deadzone_ff[i] <= DeadzoneReset;
            accel_ff[i]    <= AccelReset;
         end
         invert_mask_ff <= InvertMaskReset;
         speed_floor_ff <= VelDeadzoneReset;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_DEADZONE_X:   deadzone_ff[0]  <= csr_wdata;
            REG_DEADZONE_Y:   deadzone_ff[1]  <= csr_wdata;
            REG_DEADZONE_R:   deadzone_ff[2]  <= csr_wdata;
            REG_ACCEL_X:      accel_ff[0]     <= csr_wdata;
            REG_ACCEL_Y:      accel_ff[1]     <= csr_wdata;
            REG_ACCEL_R:      accel_ff[2]     <= csr_wdata;
            REG_INVERT_MASK:  invert_mask_ff  <= csr_wdata[MaskW-1:0];
            REG_SPEED_FLOOR:  speed_floor_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Capture the request word
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_clear_ff    <= req_type;
         in_stick_ff[0] <= req_stick_x;
         in_stick_ff[1] <= req_stick_y;
         in_stick_ff[2] <= req_stick_r;
      end
   end

   // Ramp each axis toward its target
   always_comb begin
      for (int i = 0; i < AxisCount; i++) begin
         if (in_clear_ff) begin
            vel_in[i] = '0;
         end else begin
            vel_in[i] = ramp_axis(vel_ff[i], in_stick_ff[i], deadzone_ff[i],
                                  accel_ff[i], invert_mask_ff[i], speed_floor_ff);
         end
      end
   end

   // Advance velocity state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < AxisCount; i++) begin
            vel_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < AxisCount; i++) begin
            vel_ff[i] <= vel_in[i];
         end
      end
   end

   // Load the output register; hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < AxisCount; i++) begin
            rsp_vel_ff[i] <= vel_in[i];
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_vel_x = rsp_vel_ff[0];
   assign rsp_vel_y = rsp_vel_ff[1];
   assign rsp_vel_r = rsp_vel_ff[2];

   // Velocity state never leaves the saturation range
   a_vel_range : assert property (@(posedge clock) disable iff (reset)
      (vel_ff[0] <= 16'sd16384) && (vel_ff[0] >= -16'sd16384) &&
      (vel_ff[1] <= 16'sd16384) && (vel_ff[1] >= -16'sd16384) &&
      (vel_ff[2] <= 16'sd16384) && (vel_ff[2] >= -16'sd16384))
      else $error("velocity state out of range");

   // A clear word zeroes every velocity
   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      (advance && in_clear_ff) |=>
         (vel_ff[0] == 0) && (vel_ff[1] == 0) && (vel_ff[2] == 0))
      else $error("clear word left a nonzero velocity");

   // Freshly loaded output matches the velocity state
   a_rsp_matches_state : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && (rsp_vel_ff[0] == vel_ff[0]) &&
         (rsp_vel_ff[1] == vel_ff[1]) && (rsp_vel_ff[2] == vel_ff[2]))
      else $error("output word differs from velocity state");

   // Input stall only with both stages full
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

   // State only moves when a word advances
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vel_ff[0]) && $stable(vel_ff[1]) && $stable(vel_ff[2]))
      else $error("velocity changed without an advancing word");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import tarl_pkg::*;

   // Word kinds on the request channel
   localparam logic KIND_UPDATE = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RESET_CYCLES = 12;
   localparam int PHASE_WORDS  = 150;
   localparam int PHASE_COUNT  = 9;

   // Three velocities of one response word, index 0 is x
   typedef logic [2:0][15:0] vel_triple_type;
   typedef logic [14:0] reg_set_type [8];

   // Tracks ramp state and configuration, queues the expected velocities
   class velocity_scoreboard;
      logic [14:0] deadzone [3];
      logic [14:0] accel [3];
      logic [2:0]  invert;
      logic [14:0] speed_floor;
      int          velocity [3];
      vel_triple_type expected_vel [$];
      int          errors;
      int          checked;

      function new();
         foreach (velocity[i]) begin
            velocity[i] = 0;
            deadzone[i] = DeadzoneReset;
            accel[i]    = AccelReset;
         end
         invert      = InvertMaskReset;
         speed_floor = VelDeadzoneReset;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [14:0] value);
         case (idx)
            REG_DEADZONE_X:   deadzone[0] = value;
            REG_DEADZONE_Y:   deadzone[1] = value;
            REG_DEADZONE_R:   deadzone[2] = value;
            REG_ACCEL_X:      accel[0] = value;
            REG_ACCEL_Y:      accel[1] = value;
            REG_ACCEL_R:      accel[2] = value;
            REG_INVERT_MASK:  invert = value[2:0];
            REG_SPEED_FLOOR:  speed_floor = value;
            default: ;
         endcase
      endfunction

      // Advance one axis velocity toward its stick target
      function int step_velocity(int vel, logic signed [15:0] sample, int axis);
         int target;
         int step;
         int mag;
         target = sample;
         mag = (target < 0) ? -target : target;
         if (mag < int'(deadzone[axis])) begin
            target = 0;
         end
         if (invert[axis]) begin
            target = -target;
         end
         step = (target == 0) ? 2 * int'(accel[axis]) : int'(accel[axis]);
         // climb without passing the target, descend freely
         if (vel < target) begin
            if (vel + step <= target) begin
               vel = vel + step;
            end
         end else if (vel > target) begin
            vel = vel - step;
         end
         mag = (vel < 0) ? -vel : vel;
         if (mag < int'(speed_floor)) begin
            vel = 0;
         end
         if (vel > 16384) begin
            vel = 16384;
         end
         if (vel < -16384) begin
            vel = -16384;
         end
         return vel;
      endfunction

      function void note_request(logic kind, logic signed [15:0] sx,
                                 logic signed [15:0] sy, logic signed [15:0] sr);
         logic signed [15:0] sample [3];
         vel_triple_type word;
         sample[0] = sx;
         sample[1] = sy;
         sample[2] = sr;
         for (int i = 0; i < 3; i++) begin
            velocity[i] = (kind == KIND_CLEAR) ? 0 : step_velocity(velocity[i], sample[i], i);
            word[i] = 16'(velocity[i]);
         end
         expected_vel.insert(expected_vel.size(), word);
      endfunction

      function void check_response(vel_triple_type got);
         vel_triple_type want;
         string field;
         if (expected_vel.size() == 0) begin
            $error("response word with no request pending: vel_x %0d vel_y %0d vel_r %0d",
                   $signed(got[0]), $signed(got[1]), $signed(got[2]));
            errors++;
            return;
         end
         want = expected_vel.pop_front();
         checked++;
         for (int i = 0; i < 3; i++) begin
            field = (i == 0) ? "vel_x" : (i == 1) ? "vel_y" : "vel_r";
            if (got[i] !== want[i]) begin
               $error("%s: expected %0d, actual %0d", field, $signed(want[i]), $signed(got[i]));
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return expected_vel.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_type = KIND_UPDATE;
   logic signed [15:0]  req_stick_x = '0;
   logic signed [15:0]  req_stick_y = '0;
   logic signed [15:0]  req_stick_r = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [15:0]  rsp_vel_x;
   logic signed [15:0]  rsp_vel_y;
   logic signed [15:0]  rsp_vel_r;
   logic                csr_write_en = 1'b0;
   csr_index_type       csr_index = REG_DEADZONE_X;
   logic [14:0]         csr_wdata = '0;

   velocity_scoreboard sb;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int cycle_count   = 0;
   int words_sent    = 0;
   int settings_used = 1;

   three_axis_ramp_limiter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_type    (req_type),
      .req_stick_x (req_stick_x),
      .req_stick_y (req_stick_y),
      .req_stick_r (req_stick_r),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_vel_x   (rsp_vel_x),
      .rsp_vel_y   (rsp_vel_y),
      .rsp_vel_r   (rsp_vel_r),
      .csr_write_en(csr_write_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #4 clock = ~clock;

   // Stall the response channel at random
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // Watch both channels: note accepted requests, check accepted responses
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_type, req_stick_x, req_stick_y, req_stick_r);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_response({rsp_vel_r, rsp_vel_y, rsp_vel_x});
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, sb.outstanding());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Offer one word, hold it until accepted
   task automatic send_word(input logic kind, input logic signed [15:0] sx,
                            input logic signed [15:0] sy, input logic signed [15:0] sr);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_stick_x <= sx;
      req_stick_y <= sy;
      req_stick_r <= sr;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // Hold off requests until every response is back, then let the pipe settle
   task automatic drain_words();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_config(input reg_set_type values);
      for (int i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= csr_index_type'(i);
         csr_wdata    <= values[i];
         sb.set_reg(csr_index_type'(i), values[i]);
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [14:0] rand_reg();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 15'($urandom_range(1, 2000));
         2: return 15'($urandom_range(0, 16384));
         default: return 15'($urandom);
      endcase
   endfunction

   // Stick sample: mostly in range, some at the deadzone edge, some raw 16-bit
   function automatic logic signed [15:0] rand_sample(input int axis);
      int mag;
      case ($urandom_range(0, 9))
         0: return '0;
         1, 2: begin
            mag = int'(sb.deadzone[axis]) - 1 + $urandom_range(0, 2);
            return 16'($urandom_range(0, 1) ? -mag : mag);
         end
         3: return 16'($urandom);
         4: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   // Bursts that hold a target long enough to ramp into it, with jitter and clears
   task automatic run_random(input int count);
      logic signed [15:0] target [3];
      int burst;
      int sent;
      int axis;
      sent = 0;
      while (sent < count) begin
         foreach (target[i]) target[i] = rand_sample(i);
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 4) begin
               send_word(KIND_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom));
            end else begin
               if ($urandom_range(0, 99) < 15) begin
                  axis = $urandom_range(0, 2);
                  target[axis] = rand_sample(axis);
               end
               send_word(KIND_UPDATE, target[0], target[1], target[2]);
            end
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      reg_set_type values;
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      req_idle_pct  = 23;
      rsp_stall_pct = 61;

      // Directed: full scale, raw extremes, return to center, clears, at reset values
      send_word(KIND_UPDATE, 16'sd16384, -16'sd16384, 16'sd0);
      send_word(KIND_UPDATE, 16'sd16384, -16'sd16384, 16'sd0);
      send_word(KIND_UPDATE, 16'sd32767, -16'sd32768, 16'sd1);
      send_word(KIND_UPDATE, -16'sd1, 16'sd1, -16'sd16384);
      send_word(KIND_UPDATE, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_UPDATE, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_UPDATE, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_CLEAR, 16'sd32767, -16'sd32768, -16'sd1);
      send_word(KIND_UPDATE, -16'sd32768, 16'sd32767, 16'sd16384);
      send_word(KIND_UPDATE, -16'sd32768, 16'sd32767, 16'sd16384);
      send_word(KIND_CLEAR, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_UPDATE, 16'sd12288, -16'sd4095, 16'sd4096);

      // Directed: oversized registers, full invert, wide and zero deadzones
      drain_words();
      values = '{15'd16384, 15'd0, 15'd32767, 15'd32767, 15'd0, 15'd16384,
                 15'd7, 15'd16384};
      apply_config(values);
      send_word(KIND_UPDATE, -16'sd32768, -16'sd32768, -16'sd32768);
      send_word(KIND_UPDATE, -16'sd32768, -16'sd32768, -16'sd32768);
      send_word(KIND_UPDATE, 16'sd16383, 16'sd16384, 16'sd32767);
      send_word(KIND_UPDATE, 16'sd16384, -16'sd16384, 16'sd0);
      send_word(KIND_UPDATE, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_UPDATE, 16'sd0, 16'sd0, 16'sd0);
      send_word(KIND_CLEAR, -16'sd1, 16'sd1, 16'sd0);
      send_word(KIND_UPDATE, -16'sd16384, 16'sd32767, -16'sd16385);

      // Random phases, each under its own register setting
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_words();
         req_idle_pct  = (phase < 3) ? 23 : (phase < 6) ? 61 : 0;
         rsp_stall_pct = (phase < 3) ? 61 : (phase < 6) ? 23 : 0;
         case (phase)
            0: values = '{15'd1000, 15'd2000, 15'd3000, 15'd1, 15'd500, 15'd16384,
                          15'd1, 15'd0};
            1: values = '{15'd16384, 15'd0, 15'd8192, 15'd0, 15'd4096, 15'd32767,
                          15'd2, 15'd16384};
            2: values = '{15'd32767, 15'd100, 15'd0, 15'd32767, 15'd32767, 15'd32767,
                          15'd7, 15'd32767};
            3: values = '{15'd0, 15'd0, 15'd0, 15'd2048, 15'd8192, 15'd1,
                          15'd4, 15'd300};
            8: values = '{DeadzoneReset, DeadzoneReset, DeadzoneReset,
                          AccelReset, AccelReset, AccelReset,
                          15'(InvertMaskReset), VelDeadzoneReset};
            default: begin
               foreach (values[i]) values[i] = rand_reg();
               values[int'(REG_INVERT_MASK)] = 15'($urandom_range(0, 7));
            end
         endcase
         apply_config(values);
         run_random(PHASE_WORDS);
      end

      // Let the last responses come back
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("sent %0d request words under %0d register settings, checked %0d responses",
               words_sent, settings_used, sb.checked);
      $display("mismatches: %0d, cycles: %0d", sb.errors, cycle_count);
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

@@ three_axis_ramp_limiter_unit.f @@
hdl/tarl_pkg.sv
hdl/three_axis_ramp_limiter_unit.sv
tb/testbench.sv
